>>> design/fdrsm_pkg.sv
// Shared types and constants for the frame difference row span mask block.
// No dependencies; compiled first.
package fdrsm_pkg;

    localparam int PIX_W          = 8;
    localparam int THR_W          = 7;
    localparam int RW_W           = 11;
    localparam int SPAN_W         = 10;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 11;
    localparam int MAX_ROW_WIDTH_DEF = 1024;

    localparam logic [THR_W-1:0] THR_RESET   = 7'd10;
    localparam logic [RW_W-1:0]  WIDTH_RESET = 11'd640;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIFF_THRESHOLD = 2'd0,
        CFG_ROW_WIDTH      = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0]  diff_pixel;
        logic              row_done;
        logic              span_found;
        logic [SPAN_W-1:0] span_start;
        logic [SPAN_W-1:0] span_end;
    } res_payload_t;

endpackage

>>> design/fdrsm_pix_if.sv
// Pixel pair channel: valid/ready handshake and the two co-located gray levels.
// Depends on fdrsm_pkg.
interface fdrsm_pix_if;
    logic                        valid;
    logic                        ready;
    logic [fdrsm_pkg::PIX_W-1:0] pixel_first;
    logic [fdrsm_pkg::PIX_W-1:0] pixel_second;

    modport source (output valid, output pixel_first, output pixel_second, input ready);
    modport sink   (input valid, input pixel_first, input pixel_second, output ready);
endinterface

>>> design/fdrsm_res_if.sv
// Result channel: valid/ready handshake, difference pixel and row span report.
// Depends on fdrsm_pkg.
interface fdrsm_res_if;
    logic                         valid;
    logic                         ready;
    logic [fdrsm_pkg::PIX_W-1:0]  diff_pixel;
    logic                         row_done;
    logic                         span_found;
    logic [fdrsm_pkg::SPAN_W-1:0] span_start;
    logic [fdrsm_pkg::SPAN_W-1:0] span_end;

    modport source (output valid, output diff_pixel, output row_done, output span_found,
                    output span_start, output span_end, input ready);
    modport sink   (input valid, input diff_pixel, input row_done, input span_found,
                    input span_start, input span_end, output ready);
endinterface

>>> design/frame_difference_row_span_mask.sv
// Frame difference row span mask: per-pixel absolute difference and per-row motion span.
// Depends on fdrsm_pkg, fdrsm_pix_if and fdrsm_res_if.
//
//   channel | dir | transfer when         | payload
//   pix     | in  | pix.valid & ready     | pixel_first, pixel_second
//   res     | out | res.valid & ready     | diff_pixel, row_done, span_found, span_start, span_end
//   cfg     | in  | cfg_we                | cfg_index, cfg_data (no handshake)
//
// One pixel pair per cycle while pix is ready; its result is registered in the output register or skid.
// Row state and the result are computed in one combinational step into the output register or skid.
// A two-entry output (register plus skid) keeps pix ready while one result waits on res.
// pix stalls only when both output entries are full.
// Reset clears the row state, restores the register defaults and empties the output.
module frame_difference_row_span_mask #(
    parameter int MAX_ROW_WIDTH = fdrsm_pkg::MAX_ROW_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fdrsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fdrsm_pkg::CFG_DATA_W-1:0]  cfg_data,
    fdrsm_pix_if.sink                         pix,
    fdrsm_res_if.source                       res
);

    localparam int COL_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
    localparam int CMP_W = (COL_W + 1 > fdrsm_pkg::RW_W + 1) ? COL_W + 1
                                                              : fdrsm_pkg::RW_W + 1;
    localparam int EXT_W = (COL_W > fdrsm_pkg::SPAN_W) ? COL_W : fdrsm_pkg::SPAN_W;
    localparam logic [CMP_W-1:0] MAX_W   = CMP_W'(MAX_ROW_WIDTH);
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_ROW_WIDTH - 1);

    logic [fdrsm_pkg::THR_W-1:0] thr_reg;
    logic [fdrsm_pkg::RW_W-1:0]  width_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic             hit_seen_reg, hit_seen_next;
    logic [COL_W-1:0] first_hit_reg, first_hit_next;
    logic [COL_W-1:0] last_hit_reg, last_hit_next;

    logic                    main_valid_reg, skid_valid_reg;
    fdrsm_pkg::res_payload_t main_reg, skid_reg, result;

    logic                        accept, drain;
    logic [fdrsm_pkg::PIX_W-1:0] diff;
    logic                        hit, last;
    logic [CMP_W-1:0]            rw_ext, eff_width, col_plus;
    logic                        upd_seen;
    logic [COL_W-1:0]            upd_first, upd_last;
    logic [EXT_W-1:0]            first_ext, last_ext;

    assign accept    = pix.valid && pix.ready;
    assign drain     = res.valid && res.ready;
    assign pix.ready = !skid_valid_reg;

    always_comb
    begin
        diff = (pix.pixel_first >= pix.pixel_second) ? pix.pixel_first - pix.pixel_second
                                                     : pix.pixel_second - pix.pixel_first;
        hit  = diff > {1'b0, thr_reg};

        rw_ext = CMP_W'(width_reg);
        if (rw_ext == '0)
            eff_width = CMP_W'(1);
        else if (rw_ext > MAX_W)
            eff_width = MAX_W;
        else
            eff_width = rw_ext;
        col_plus = CMP_W'(col_reg) + CMP_W'(1);
        last     = col_plus >= eff_width;

        upd_seen  = hit_seen_reg || hit;
        upd_first = (hit && !hit_seen_reg) ? col_reg : first_hit_reg;
        upd_last  = hit ? col_reg : last_hit_reg;
        first_ext = EXT_W'(upd_first);
        last_ext  = EXT_W'(upd_last);

        result.diff_pixel = diff;
        result.row_done   = last;
        result.span_found = last && upd_seen;
        result.span_start = (last && upd_seen) ? first_ext[fdrsm_pkg::SPAN_W-1:0] : '0;
        result.span_end   = (last && upd_seen) ? last_ext[fdrsm_pkg::SPAN_W-1:0] : '0;

        if (last)
        begin
            col_next       = '0;
            hit_seen_next  = 1'b0;
            first_hit_next = '0;
            last_hit_next  = '0;
        end
        else
        begin
            col_next       = col_reg + COL_W'(1);
            hit_seen_next  = upd_seen;
            first_hit_next = upd_first;
            last_hit_next  = upd_last;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= fdrsm_pkg::THR_RESET;
            width_reg <= fdrsm_pkg::WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fdrsm_pkg::CFG_DIFF_THRESHOLD: thr_reg   <= cfg_data[fdrsm_pkg::THR_W-1:0];
                fdrsm_pkg::CFG_ROW_WIDTH:      width_reg <= cfg_data[fdrsm_pkg::RW_W-1:0];
                default: ;
            endcase
        end
    end

    // row state: advance on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            hit_seen_reg  <= 1'b0;
            first_hit_reg <= '0;
            last_hit_reg  <= '0;
        end
        else if (accept)
        begin
            col_reg       <= col_next;
            hit_seen_reg  <= hit_seen_next;
            first_hit_reg <= first_hit_next;
            last_hit_reg  <= last_hit_next;
        end
    end

    // output register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!main_valid_reg || drain)
            begin
                main_valid_reg <= skid_valid_reg || accept;
                skid_valid_reg <= 1'b0;
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || drain)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (accept)
                main_reg <= result;
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

    assign res.valid      = main_valid_reg;
    assign res.diff_pixel = main_reg.diff_pixel;
    assign res.row_done   = main_reg.row_done;
    assign res.span_found = main_reg.span_found;
    assign res.span_start = main_reg.span_start;
    assign res.span_end   = main_reg.span_end;

`ifndef SYNTH
    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held while output register empty");

    a_span_only_at_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.row_done) |-> (!res.span_found && res.span_start == '0
                                          && res.span_end == '0))
        else $error("span fields set on a pixel that does not end a row");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_MAX)
        else $error("column count beyond maximum row width");

    a_span_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        hit_seen_reg |-> (first_hit_reg <= last_hit_reg && last_hit_reg < col_reg))
        else $error("tracked span out of order");
`endif

endmodule
